// ===== hdl/mcbd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-click button detector: shared types, codes and register constants.
package mcbd_pkg;

   // Configuration register file
   localparam int CFG_WIDTH       = 16;
   localparam int CFG_INDEX_WIDTH = 3;

   typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_type;
   typedef logic [CFG_WIDTH-1:0]       cfg_value_type;

   localparam cfg_index_type REG_PRESS_MIN  = 3'd0;
   localparam cfg_index_type REG_PRESS_MAX  = 3'd1;
   localparam cfg_index_type REG_LONG_PRESS = 3'd2;
   localparam cfg_index_type REG_MULTI_GAP  = 3'd3;

   localparam cfg_value_type PRESS_MIN_RESET  = 16'd2;
   localparam cfg_value_type PRESS_MAX_RESET  = 16'd50;
   localparam cfg_value_type LONG_PRESS_RESET = 16'd100;
   localparam cfg_value_type MULTI_GAP_RESET  = 16'd30;

   // Reported events
   localparam int EVENT_WIDTH = 3;
   typedef logic [EVENT_WIDTH-1:0] key_event_type;

   localparam key_event_type EV_NONE   = 3'd0;
   localparam key_event_type EV_SINGLE = 3'd1;
   localparam key_event_type EV_TRIPLE = 3'd3;
   localparam key_event_type EV_LONG   = 3'd4;

   // Press counter
   localparam int PRESS_COUNT_WIDTH = 3;
   typedef logic [PRESS_COUNT_WIDTH-1:0] press_count_type;
   localparam press_count_type PRESS_COUNT_MAX = 3'd7;

   // Key phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DOWN = 2'd1,
      PH_HELD = 2'd2,
      PH_UP   = 2'd3
   } phase_type;

endpackage

// ===== hdl/multi_click_button_detector.sv =====
`timescale 1ns / 1ps
// Top level of the multi-click and long-press button detector.
//
// One item is one sampled key level per scan tick (0 pressed, 1 released), and every
// item gives exactly one result item: no event, a single, double or triple click, or a
// long press. The block accepts one item in every clock cycle while rsp_ready is high.
// An accepted item waits in an input register, the phase machine and its saturating
// hold and gap counters are updated by a short compare-and-increment path, and the
// event lands in an output register, so a result passes both registers in turn. The
// input register also acts as a skid stage: while a result waits for rsp_ready, one
// further item is still taken. The user must write the four thresholds through the
// csr_ port only while the block is idle; the block does not enforce this. Writes to
// indexes beyond the list are ignored. COUNT_BITS sets the width of the hold and gap
// counters, which saturate at their all-ones value.
module multi_click_button_detector #(
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input items
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_pin_level,
   // Result items
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mcbd_pkg::key_event_type        rsp_key_event,
   // Configuration writes
   input  logic                           csr_we,
   input  mcbd_pkg::cfg_index_type        csr_index,
   input  mcbd_pkg::cfg_value_type        csr_wdata
);
   import mcbd_pkg::*;

   // Compares are made at the wider of the counter and the register widths.
   localparam int CMP_BITS = (COUNT_BITS > CFG_WIDTH) ? COUNT_BITS : CFG_WIDTH;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam count_type COUNT_ONE = count_type'(1);

   // Configuration registers
   cfg_value_type press_min_ff, press_max_ff, long_press_ff, multi_gap_ff;

   // Input register (skid stage)
   logic in_valid_ff, in_valid_in;
   logic in_pin_ff;

   // Output register
   logic          out_valid_ff, out_valid_in;
   key_event_type out_event_ff, out_event_in;

   // Key state
   phase_type       phase_ff, phase_in;
   count_type       hold_ff, hold_in;
   count_type       gap_ff, gap_in;
   press_count_type press_count_ff, press_count_in;
   logic            mark_ff, mark_in;

   logic    advance;
   logic    released;
   cmp_type hold_cmp, gap_next_cmp;
   cmp_type press_min_cmp, press_max_cmp, long_press_cmp, multi_gap_cmp;
   count_type gap_step;
   count_type hold_base;

   // The processing step moves the input item into the output register whenever that
   // register is empty or its result is being taken in the same cycle.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = out_event_ff;

   assign released = in_pin_ff;

   assign hold_cmp       = cmp_type'(hold_ff);
   assign press_min_cmp  = cmp_type'(press_min_ff);
   assign press_max_cmp  = cmp_type'(press_max_ff);
   assign long_press_cmp = cmp_type'(long_press_ff);
   assign multi_gap_cmp  = cmp_type'(multi_gap_ff);

   // While idle the gap keeps counting once a release has been seen.
   always_comb begin
      if (mark_ff && (gap_ff != COUNT_MAX)) begin
         gap_step = gap_ff + COUNT_ONE;
      end else begin
         gap_step = gap_ff;
      end
   end
   assign gap_next_cmp = cmp_type'(gap_step);

   // Phase machine: next state and the event of the current item.
   always_comb begin
      phase_in       = phase_ff;
      hold_in        = hold_ff;
      gap_in         = gap_ff;
      press_count_in = press_count_ff;
      mark_in        = mark_ff;
      out_event_in   = EV_NONE;
      hold_base      = hold_ff;

      case (phase_ff)
         PH_IDLE: begin
            phase_in = released ? PH_IDLE : PH_DOWN;
            gap_in   = gap_step;
            if ((hold_cmp < long_press_cmp) && (hold_cmp > press_max_cmp)) begin
               // A press that ran too long for a click but short of a long press.
               hold_in        = '0;
               gap_in         = '0;
               press_count_in = '0;
               mark_in        = 1'b0;
            end else if ((gap_next_cmp > multi_gap_cmp) && (hold_cmp > press_min_cmp) &&
                         (hold_cmp < press_max_cmp)) begin
               // The release gap has settled the click count.
               if ((press_count_ff >= press_count_type'(EV_SINGLE)) &&
                   (press_count_ff <= press_count_type'(EV_TRIPLE))) begin
                  out_event_in = key_event_type'(press_count_ff);
               end
               hold_in        = '0;
               gap_in         = '0;
               press_count_in = '0;
               mark_in        = 1'b0;
            end
         end
         PH_DOWN: begin
            phase_in = PH_HELD;
            if (press_count_ff != PRESS_COUNT_MAX) begin
               press_count_in = press_count_ff + press_count_type'(1);
            end
            mark_in = 1'b0;
            hold_in = '0;
         end
         PH_HELD: begin
            if (hold_cmp > long_press_cmp) begin
               // Long press; clearing the counters lets it repeat while the key stays down.
               out_event_in   = EV_LONG;
               hold_base      = '0;
               gap_in         = '0;
               press_count_in = '0;
               mark_in        = 1'b0;
            end
            if (released) begin
               phase_in = PH_UP;
               hold_in  = hold_base;
            end else if (hold_base != COUNT_MAX) begin
               hold_in = hold_base + COUNT_ONE;
            end else begin
               hold_in = hold_base;
            end
         end
         PH_UP: begin
            mark_in  = 1'b1;
            gap_in   = '0;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Handshake bookkeeping for both registers.
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = in_valid_ff;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pin_ff <= req_pin_level;
      end
      if (advance && in_valid_ff) begin
         out_event_ff <= out_event_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         hold_ff        <= '0;
         gap_ff         <= '0;
         press_count_ff <= '0;
         mark_ff        <= 1'b0;
      end else if (advance && in_valid_ff) begin
         phase_ff       <= phase_in;
         hold_ff        <= hold_in;
         gap_ff         <= gap_in;
         press_count_ff <= press_count_in;
         mark_ff        <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_min_ff  <= PRESS_MIN_RESET;
         press_max_ff  <= PRESS_MAX_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         multi_gap_ff  <= MULTI_GAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PRESS_MIN:  press_min_ff  <= csr_wdata;
            REG_PRESS_MAX:  press_max_ff  <= csr_wdata;
            REG_LONG_PRESS: long_press_ff <= csr_wdata;
            REG_MULTI_GAP:  multi_gap_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== hdl/mcbd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the multi-click button detector, bound to the top level.
module mcbd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input mcbd_pkg::key_event_type rsp_key_event
);
   import mcbd_pkg::*;

   // A result that is not taken stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_event))
      else $error("result item changed or vanished while stalled");

   // Only event codes from EV_NONE up to EV_LONG are ever reported.
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_event <= EV_LONG))
      else $error("undefined event code on the result port");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present straight after reset");

   // A result on an empty port comes from an input item that was never stalled.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without a matching input item");

endmodule

bind multi_click_button_detector mcbd_checker u_mcbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_key_event (rsp_key_event)
);
